FILE: rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Transaction types, phase encoding and command codes shared by the
// sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_START_WR = 2'd1,
    MODE_START_RD = 2'd2,
    MODE_EVENT    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ADDR     = 4'd1,
    PH_ADDR_ACK = 4'd2,
    PH_SEND     = 4'd3,
    PH_DATA_ACK = 4'd4,
    PH_RECV     = 4'd5,
    PH_ACK      = 4'd6,
    PH_NACK     = 4'd7,
    PH_STOP     = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RDACK = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_ACKB  = 3'd5,
    CMD_STOP  = 3'd6
  } cmd_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] dev_address;
    logic [7:0] length;
    logic       send_stop;
    logic [3:0] load_index;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] tx_byte;
    logic       nack_select;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_byte;
    logic       done_res;
  } out_item_t;

endpackage

FILE: rtl/i2c_master_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Steps a byte-level I2C controller through one transaction, issuing one
// command per completed controller command and delivering received bytes.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_stall     in_data  (i2cms_pkg::in_item_t)
//   out      output     out_valid / out_stall   out_data (i2cms_pkg::out_item_t)
//
// A transaction may be accepted in every cycle in which in_stall is low.
// The result appears in the output register on the cycle after acceptance.
// Load transactions write the transmit buffer when load_index is below its depth and give no result.
// in_stall is high only while a result is held and out_stall is high.
// Synchronous reset returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
  parameter int TX_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cms_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cms_pkg::out_item_t  out_data
);
  import i2cms_pkg::*;

  localparam int BUF_DEPTH = (TX_DEPTH < 16) ? TX_DEPTH : 16;
  localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int BUF_SLOTS = 2 ** IDX_W;

  phase_t     phase, phase_next;
  logic       is_write, is_write_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] target_address, target_address_next;
  logic       stop_at_end, stop_at_end_next;
  logic [7:0] tx_buffer [BUF_SLOTS];

  out_item_t  result;
  logic       accept;
  logic       has_result;
  logic [7:0] buf_byte;
  logic [8:0] clamp_len;
  phase_t     after_transfer;

  assign in_stall   = out_valid && out_stall;
  assign accept     = in_valid && !in_stall;
  assign has_result = (in_data.mode != MODE_LOAD);
  assign buf_byte   = tx_buffer[byte_position[IDX_W-1:0]];
  assign clamp_len  = ({1'b0, in_data.length} > 9'(TX_DEPTH)) ? 9'(TX_DEPTH)
                                                              : {1'b0, in_data.length};
  assign after_transfer = stop_at_end ? PH_STOP : PH_IDLE;

  always_ff @(posedge clk) begin
    if (accept && in_data.mode == MODE_LOAD &&
        {5'b0, in_data.load_index} < 9'(BUF_DEPTH)) begin
      tx_buffer[in_data.load_index[IDX_W-1:0]] <= in_data.data_byte;
    end
  end

  always_comb begin
    phase_next          = phase;
    is_write_next       = is_write;
    byte_position_next  = byte_position;
    byte_count_next     = byte_count;
    target_address_next = target_address;
    stop_at_end_next    = stop_at_end;
    unique case (in_data.mode)
      MODE_LOAD: begin
      end
      MODE_START_WR, MODE_START_RD: begin
        is_write_next       = (in_data.mode == MODE_START_WR);
        target_address_next = in_data.dev_address;
        byte_position_next  = 8'd0;
        byte_count_next     = (in_data.mode == MODE_START_WR) ? clamp_len[7:0]
                                                              : in_data.length;
        stop_at_end_next    = (in_data.mode == MODE_START_WR) ? in_data.send_stop : 1'b1;
        phase_next          = PH_ADDR;
      end
      MODE_EVENT: begin
        case (phase)
          PH_ADDR:     phase_next = PH_ADDR_ACK;
          PH_ADDR_ACK: begin
            if (byte_count == 8'd0) begin
              phase_next = after_transfer;
            end else begin
              phase_next = is_write ? PH_SEND : PH_RECV;
            end
          end
          PH_SEND: begin
            byte_position_next = byte_position + 8'd1;
            phase_next         = PH_DATA_ACK;
          end
          PH_DATA_ACK: begin
            phase_next = (byte_position >= byte_count) ? after_transfer : PH_SEND;
          end
          PH_RECV: begin
            phase_next = (({1'b0, byte_position} + 9'd1) >= {1'b0, byte_count}) ? PH_NACK
                                                                               : PH_ACK;
          end
          PH_ACK: begin
            byte_position_next = byte_position + 8'd1;
            phase_next         = PH_RECV;
          end
          PH_NACK:     phase_next = PH_STOP;
          PH_STOP:     phase_next = PH_IDLE;
          PH_IDLE: begin
            byte_position_next = 8'd0;
            byte_count_next    = 8'd0;
          end
          default:     phase_next = PH_IDLE;
        endcase
      end
    endcase
  end

  always_comb begin
    result = '0;
    unique case (in_data.mode)
      MODE_LOAD: begin
      end
      MODE_START_WR, MODE_START_RD: result.command = CMD_START;
      MODE_EVENT: begin
        case (phase)
          PH_ADDR: begin
            result.command = CMD_SEND;
            result.tx_byte = target_address;
          end
          PH_ADDR_ACK, PH_DATA_ACK: result.command = CMD_RDACK;
          PH_SEND: begin
            result.command = CMD_SEND;
            result.tx_byte = buf_byte;
          end
          PH_RECV: result.command = CMD_RECV;
          PH_ACK, PH_NACK: begin
            result.command     = CMD_ACKB;
            result.nack_select = (phase == PH_NACK);
            result.rx_valid    = 1'b1;
            result.rx_index    = byte_position;
            result.rx_byte     = in_data.data_byte;
          end
          PH_STOP: result.command = CMD_STOP;
          PH_IDLE: result.done_res = 1'b1;
          default: result.command = CMD_NONE;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      is_write       <= 1'b0;
      byte_position  <= 8'd0;
      byte_count     <= 8'd0;
      target_address <= 8'd0;
      stop_at_end    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        is_write       <= is_write_next;
        byte_position  <= byte_position_next;
        byte_count     <= byte_count_next;
        target_address <= target_address_next;
        stop_at_end    <= stop_at_end_next;
        out_valid      <= has_result;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_data <= result;
    end
  end

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.mode == MODE_LOAD |=> !out_valid)
    else $error("Load transaction produced a result.");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.mode == MODE_START_WR || in_data.mode == MODE_START_RD)
    |=> phase == PH_ADDR && byte_position == 8'd0)
    else $error("Start did not restart the sequence.");

  a_write_position: assert property (@(posedge clk) disable iff (rst)
    is_write |-> byte_position <= byte_count)
    else $error("Write position ran past the byte count.");

  a_write_clamp: assert property (@(posedge clk) disable iff (rst)
    is_write |-> {1'b0, byte_count} <= 9'(TX_DEPTH))
    else $error("Write length exceeds the transmit buffer.");

  a_rx_only_ackb: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rx_valid |-> out_data.command == CMD_ACKB && !out_data.done_res)
    else $error("Received byte delivered outside an acknowledge command.");

endmodule
